// ===== rtl/sedd_pkg.sv =====
// Shared constants and codes for the serpentine error diffusion ditherer.
// No dependencies.
`timescale 1ns / 1ps

package sedd_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int PAL_ENTRIES  = 256;
   localparam int ERROR_BITS   = 16;

   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int WIDTH_W      = COL_W + 1;
   localparam int ERR_AW       = COL_W + 1;
   localparam int ERR_DW       = 3 * ERROR_BITS;
   localparam int PAL_AW       = $clog2(PAL_ENTRIES);
   localparam int PAL_DW       = 24;

   localparam int PROD_W       = ERROR_BITS + 8;
   localparam int MAG_W        = PROD_W - 1;
   localparam int Q_W          = ERROR_BITS + 1;
   localparam int V_W          = ERROR_BITS + 2;
   localparam int T_W          = V_W + 1;
   localparam int SQ_W         = 2 * T_W;
   localparam int DIST_W       = SQ_W + 2;
   localparam int PART_W       = V_W + 1;

   // floor(n / 100) = (n * RECIP_MULT) >> RECIP_SHIFT for n < 2**MAG_W
   localparam int RECIP_SHIFT  = MAG_W + 7;
   localparam longint RECIP_MULT = ((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100;
   localparam int RECIP_W      = MAG_W + 1;

   localparam logic [DIST_W-1:0] SEARCH_LIMIT = DIST_W'(32'h0002fa04);

   localparam logic [1:0] OP_FRAME   = 2'd0;
   localparam logic [1:0] OP_PALETTE = 2'd1;
   localparam logic [1:0] OP_PIXEL   = 2'd2;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_LEVEL  = 2'd1;
   localparam logic [1:0] CSR_TRANS  = 2'd2;

endpackage

// ===== rtl/sedd_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module sedd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== rtl/serpentine_error_diffusion_dither.sv =====
// Serpentine error diffusion ditherer top level. Frame start: accepted, then both error rows
// are cleared, 2*MAX_WIDTH entries. Opaque pixel: the palette search scans the entries below
// transparent_index (one entry per cycle) before the result word; a transparent pixel skips
// the search; fewer spread writes are made where spread targets fall off the row. The next word
// is accepted once the result word is registered, after the last pixel of a row only once that
// row is cleared; a held result word stalls. Sync reset, then both rows clear. Uses sedd_pkg, sedd_ram.
`timescale 1ns / 1ps

module serpentine_error_diffusion_dither (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_entry_index,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        req_opaque,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_palette_index,
   output logic [9:0]  rsp_column,
   output logic        rsp_row_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);

   localparam int EB = sedd_pkg::ERROR_BITS;
   localparam int CW = sedd_pkg::COL_W;
   localparam int WW = sedd_pkg::WIDTH_W;
   localparam int AW = sedd_pkg::ERR_AW;
   localparam int VW = sedd_pkg::V_W;
   localparam int PW = sedd_pkg::PART_W;
   localparam logic [sedd_pkg::RECIP_W-1:0] RECIP =
      sedd_pkg::RECIP_W'(sedd_pkg::RECIP_MULT);

   typedef enum logic [12:0] {
      ST_CLEAR  = 13'b0000000000001,
      ST_IDLE   = 13'b0000000000010,
      ST_ACC_RD = 13'b0000000000100,
      ST_ACC_GT = 13'b0000000001000,
      ST_MUL    = 13'b0000000010000,
      ST_DIV    = 13'b0000000100000,
      ST_SUB    = 13'b0000001000000,
      ST_SEARCH = 13'b0000010000000,
      ST_COL_RD = 13'b0000100000000,
      ST_COL_GT = 13'b0001000000000,
      ST_SP_RD  = 13'b0010000000000,
      ST_SP_WR  = 13'b0100000000000,
      ST_FINISH = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [WW-1:0] width_ff, width_in;
   logic [6:0]    level_ff, level_in;
   logic [7:0]    trans_ff, trans_in;
   logic          parity_ff, parity_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [7:0]    pix_ff [3];
   logic [7:0]    pix_in [3];
   logic          opaque_ff, opaque_in;
   logic [WW-1:0] w_ff, w_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] pu_ff, pu_in;
   logic          last_ff, last_in;
   logic signed [EB-1:0] acc_ff [3];
   logic signed [EB-1:0] acc_in [3];
   logic [1:0]    ch_ff, ch_in;
   logic signed [sedd_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [sedd_pkg::Q_W-1:0] q_ff, q_in;
   logic          qneg_ff, qneg_in;
   logic signed [VW-1:0] v_ff [3];
   logic signed [VW-1:0] v_in [3];
   logic [8:0]    issue_ff, issue_in;
   logic          s1_ff, s1_in, s2_ff, s2_in;
   logic [7:0]    i1_ff, i1_in, i2_ff, i2_in;
   logic [sedd_pkg::SQ_W-1:0] sq_ff [3];
   logic [sedd_pkg::SQ_W-1:0] sq_in [3];
   logic [sedd_pkg::DIST_W-1:0] least_ff, least_in;
   logic [7:0]    chosen_ff, chosen_in;
   logic signed [VW-1:0] e_ff [3];
   logic signed [VW-1:0] e_in [3];
   logic [1:0]    tg_ff, tg_in;
   logic [AW-1:0] clr_ff, clr_in, clr_end_ff, clr_end_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_index_ff, rsp_index_in;
   logic [CW-1:0] rsp_col_ff, rsp_col_in;
   logic          rsp_last_ff, rsp_last_in;

   logic                       pal_we, pal_re;
   logic [sedd_pkg::PAL_AW-1:0] pal_wa, pal_ra;
   logic [sedd_pkg::PAL_DW-1:0] pal_wd, pal_rd;
   logic                       err_we, err_re;
   logic [AW-1:0]              err_wa, err_ra;
   logic [sedd_pkg::ERR_DW-1:0] err_wd, err_rd;

   sedd_ram #(.WIDTH(sedd_pkg::PAL_DW), .DEPTH(sedd_pkg::PAL_ENTRIES)) u_pal (
      .clock(clock), .wr_en(pal_we), .wr_addr(pal_wa), .wr_data(pal_wd),
      .rd_en(pal_re), .rd_addr(pal_ra), .rd_data(pal_rd)
   );

   sedd_ram #(.WIDTH(sedd_pkg::ERR_DW), .DEPTH(2 * sedd_pkg::MAX_WIDTH)) u_err (
      .clock(clock), .wr_en(err_we), .wr_addr(err_wa), .wr_data(err_wd),
      .rd_en(err_re), .rd_addr(err_ra), .rd_data(err_rd)
   );

   function automatic logic signed [PW-1:0] div16(input logic signed [PW+2:0] x);
      logic signed [PW+2:0] y;
      y = x[PW+2] ? (x + (PW+3)'(15)) : x;
      return PW'(y >>> 4);
   endfunction

   function automatic logic signed [PW-1:0] share(input logic signed [VW-1:0] e,
                                                  input logic [1:0] sel);
      logic signed [PW+2:0] ex;
      logic signed [PW-1:0] p7, p5, p3, r;
      ex = (PW+3)'(e);
      p7 = div16((ex <<< 3) - ex);
      p5 = div16((ex <<< 2) + ex);
      p3 = div16((ex <<< 1) + ex);
      r  = PW'(e) - p7 - p5 - p3;
      case (sel)
         2'd0:    return p7;
         2'd1:    return p5;
         2'd2:    return p3;
         default: return r;
      endcase
   endfunction

   function automatic logic signed [EB-1:0] sat_add(input logic signed [EB-1:0] a,
                                                    input logic signed [PW-1:0] p);
      logic signed [PW+1:0] s;
      s = (PW+2)'(a) + (PW+2)'(p);
      if (s > (PW+2)'((1 << (EB - 1)) - 1)) begin
         return {1'b0, {(EB-1){1'b1}}};
      end else if (s < -(PW+2)'(1 << (EB - 1))) begin
         return {1'b1, {(EB-1){1'b0}}};
      end
      return EB'(s);
   endfunction

   // spreading target for current step
   logic signed [CW+1:0] tcol;
   logic                 tvalid;
   logic [AW-1:0]        taddr;
   logic [WW-1:0]        w_acc, wm1_acc, p_acc;
   logic [sedd_pkg::MAG_W-1:0] mag;
   logic [sedd_pkg::MAG_W+sedd_pkg::RECIP_W-1:0] qfull;
   logic signed [VW-1:0] qs;
   logic signed [sedd_pkg::T_W-1:0] tdiff [3];
   logic signed [2*sedd_pkg::T_W-1:0] tsq [3];
   logic [sedd_pkg::DIST_W-1:0] dist_sum;
   logic [8:0] lim;

   always_comb begin
      logic signed [CW+1:0] dir;
      dir = parity_ff ? -(CW+2)'(1) : (CW+2)'(1);
      case (tg_ff)
         2'd0:    tcol = (CW+2)'(col_ff) + dir;
         2'd1:    tcol = (CW+2)'(col_ff);
         2'd2:    tcol = (CW+2)'(col_ff) - dir;
         default: tcol = (CW+2)'(col_ff) + dir;
      endcase
      tvalid = !tcol[CW+1] && (tcol[WW-1:0] < w_ff);
      taddr  = {(tg_ff == 2'd0) ? parity_ff : ~parity_ff, tcol[CW-1:0]};
   end

   always_comb begin
      if (width_ff == '0) begin
         w_acc = WW'(1);
      end else if (width_ff > WW'(sedd_pkg::MAX_WIDTH)) begin
         w_acc = WW'(sedd_pkg::MAX_WIDTH);
      end else begin
         w_acc = width_ff;
      end
      wm1_acc = w_acc - WW'(1);
      p_acc   = (WW'(pos_ff) > wm1_acc) ? wm1_acc : WW'(pos_ff);
   end

   assign mag   = prod_ff[sedd_pkg::PROD_W-1] ? sedd_pkg::MAG_W'(-prod_ff)
                                              : prod_ff[sedd_pkg::MAG_W-1:0];
   assign qfull = (sedd_pkg::MAG_W+sedd_pkg::RECIP_W)'(mag) *
                  (sedd_pkg::MAG_W+sedd_pkg::RECIP_W)'(RECIP);
   assign qs    = qneg_ff ? -VW'(q_ff) : VW'(q_ff);
   assign lim   = {1'b0, trans_ff};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         tdiff[k] = sedd_pkg::T_W'(v_ff[k]) -
                    $signed({{(sedd_pkg::T_W-8){1'b0}}, pal_rd[8*k +: 8]});
         tsq[k]   = tdiff[k] * tdiff[k];
      end
      dist_sum = sedd_pkg::DIST_W'(sq_ff[0]) + sedd_pkg::DIST_W'(sq_ff[1]) +
                 sedd_pkg::DIST_W'(sq_ff[2]);
   end

   always_comb begin
      state_in   = state_ff;
      width_in   = width_ff;
      level_in   = level_ff;
      trans_in   = trans_ff;
      parity_in  = parity_ff;
      pos_in     = pos_ff;
      pix_in     = pix_ff;
      opaque_in  = opaque_ff;
      w_in       = w_ff;
      col_in     = col_ff;
      pu_in      = pu_ff;
      last_in    = last_ff;
      acc_in     = acc_ff;
      ch_in      = ch_ff;
      prod_in    = prod_ff;
      q_in       = q_ff;
      qneg_in    = qneg_ff;
      v_in       = v_ff;
      issue_in   = issue_ff;
      s1_in      = 1'b0;
      s2_in      = s1_ff;
      i1_in      = i1_ff;
      i2_in      = i1_ff;
      sq_in      = sq_ff;
      least_in   = least_ff;
      chosen_in  = chosen_ff;
      e_in       = e_ff;
      tg_in      = tg_ff;
      clr_in     = clr_ff;
      clr_end_in = clr_end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_index_in = rsp_index_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_last_in  = rsp_last_ff;

      pal_we = 1'b0;
      pal_wa = req_entry_index;
      pal_wd = {req_blue, req_green, req_red};
      pal_re = 1'b0;
      pal_ra = chosen_ff;
      err_we = 1'b0;
      err_wa = clr_ff;
      err_wd = '0;
      err_re = 1'b0;
      err_ra = {parity_ff, col_ff};

      if (csr_valid) begin
         case (csr_index)
            sedd_pkg::CSR_WIDTH: width_in = csr_data;
            sedd_pkg::CSR_LEVEL: level_in = csr_data[6:0];
            sedd_pkg::CSR_TRANS: trans_in = csr_data[7:0];
            default: ;
         endcase
      end

      for (int k = 0; k < 3; k++) begin
         sq_in[k] = sedd_pkg::SQ_W'(tsq[k]);
      end

      case (state_ff)
         ST_CLEAR: begin
            err_we = 1'b1;
            if (clr_ff == clr_end_ff) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_opcode)
                  sedd_pkg::OP_FRAME: begin
                     parity_in  = 1'b0;
                     pos_in     = '0;
                     clr_in     = '0;
                     clr_end_in = '1;
                     state_in   = ST_CLEAR;
                  end
                  sedd_pkg::OP_PALETTE: pal_we = 1'b1;
                  sedd_pkg::OP_PIXEL: begin
                     pix_in[0] = req_red;
                     pix_in[1] = req_green;
                     pix_in[2] = req_blue;
                     opaque_in = req_opaque;
                     w_in      = w_acc;
                     pu_in     = p_acc[CW-1:0];
                     col_in    = parity_ff ? CW'(wm1_acc - p_acc) : p_acc[CW-1:0];
                     last_in   = (p_acc == wm1_acc);
                     state_in  = ST_ACC_RD;
                  end
                  default: ;
               endcase
            end
         end
         ST_ACC_RD: begin
            err_re   = 1'b1;
            state_in = ST_ACC_GT;
         end
         ST_ACC_GT: begin
            for (int k = 0; k < 3; k++) begin
               acc_in[k] = err_rd[EB*k +: EB];
            end
            ch_in    = 2'd0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = acc_ff[ch_ff] * $signed({1'b0, level_ff});
            state_in = ST_DIV;
         end
         ST_DIV: begin
            q_in     = qfull[sedd_pkg::RECIP_SHIFT +: sedd_pkg::Q_W];
            qneg_in  = prod_ff[sedd_pkg::PROD_W-1];
            state_in = ST_SUB;
         end
         ST_SUB: begin
            v_in[ch_ff] = $signed({{(VW-8){1'b0}}, pix_ff[ch_ff]}) - qs;
            if (ch_ff == 2'd2) begin
               issue_in  = '0;
               least_in  = sedd_pkg::SEARCH_LIMIT;
               chosen_in = opaque_ff ? 8'd0 : trans_ff;
               state_in  = opaque_ff ? ST_SEARCH : ST_COL_RD;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_SEARCH: begin
            if (issue_ff < lim) begin
               pal_re   = 1'b1;
               pal_ra   = issue_ff[7:0];
               s1_in    = 1'b1;
               i1_in    = issue_ff[7:0];
               issue_in = issue_ff + 9'd1;
            end
            if (s2_ff && (dist_sum < least_ff)) begin
               least_in  = dist_sum;
               chosen_in = i2_ff;
            end
            if (!(issue_ff < lim) && !s1_ff && !s2_ff) begin
               state_in = ST_COL_RD;
            end
         end
         ST_COL_RD: begin
            pal_re   = 1'b1;
            state_in = ST_COL_GT;
         end
         ST_COL_GT: begin
            for (int k = 0; k < 3; k++) begin
               e_in[k] = $signed({{(VW-8){1'b0}}, pal_rd[8*k +: 8]}) - v_ff[k];
            end
            tg_in    = 2'd0;
            state_in = ST_SP_RD;
         end
         ST_SP_RD: begin
            if (tvalid) begin
               err_re   = 1'b1;
               err_ra   = taddr;
               state_in = ST_SP_WR;
            end else if (tg_ff == 2'd3) begin
               state_in = ST_FINISH;
            end else begin
               tg_in = tg_ff + 2'd1;
            end
         end
         ST_SP_WR: begin
            err_we = 1'b1;
            err_wa = taddr;
            for (int k = 0; k < 3; k++) begin
               err_wd[EB*k +: EB] = sat_add(err_rd[EB*k +: EB], share(e_ff[k], tg_ff));
            end
            if (tg_ff == 2'd3) begin
               state_in = ST_FINISH;
            end else begin
               tg_in    = tg_ff + 2'd1;
               state_in = ST_SP_RD;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = chosen_ff;
               rsp_col_in   = col_ff;
               rsp_last_in  = last_ff;
               if (last_ff) begin
                  parity_in  = ~parity_ff;
                  pos_in     = '0;
                  clr_in     = {parity_ff, {CW{1'b0}}};
                  clr_end_in = {parity_ff, {CW{1'b1}}};
                  state_in   = ST_CLEAR;
               end else begin
                  pos_in   = pu_ff + CW'(1);
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         width_ff     <= WW'(sedd_pkg::MAX_WIDTH);
         level_ff     <= 7'd100;
         trans_ff     <= 8'd255;
         parity_ff    <= 1'b0;
         pos_ff       <= '0;
         clr_ff       <= '0;
         clr_end_ff   <= '1;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         level_ff     <= level_in;
         trans_ff     <= trans_in;
         parity_ff    <= parity_in;
         pos_ff       <= pos_in;
         clr_ff       <= clr_in;
         clr_end_ff   <= clr_end_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pix_ff       <= pix_in;
      opaque_ff    <= opaque_in;
      w_ff         <= w_in;
      col_ff       <= col_in;
      pu_ff        <= pu_in;
      last_ff      <= last_in;
      acc_ff       <= acc_in;
      ch_ff        <= ch_in;
      prod_ff      <= prod_in;
      q_ff         <= q_in;
      qneg_ff      <= qneg_in;
      v_ff         <= v_in;
      issue_ff     <= issue_in;
      i1_ff        <= i1_in;
      i2_ff        <= i2_in;
      sq_ff        <= sq_in;
      least_ff     <= least_in;
      chosen_ff    <= chosen_in;
      e_ff         <= e_in;
      tg_ff        <= tg_in;
      rsp_index_ff <= rsp_index_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_palette_index = rsp_index_ff;
   assign rsp_column        = rsp_col_ff;
   assign rsp_row_last      = rsp_last_ff;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for serpentine_error_diffusion_dither: directed tests, then random frames.
// Predicts every result word from its own model of the ditherer; depends on sedd_pkg.
`timescale 1ns / 1ps

module tb_top;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int IDLE_CYCLES = 2 * sedd_pkg::MAX_WIDTH + 300;

   typedef struct packed {
      logic [7:0] palette_index;
      logic [9:0] column;
      logic       row_last;
   } dither_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = sedd_pkg::OP_FRAME;
   logic [7:0]  req_entry_index = '0;
   logic [7:0]  req_red = '0;
   logic [7:0]  req_green = '0;
   logic [7:0]  req_blue = '0;
   logic        req_opaque = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_palette_index;
   logic [9:0]  rsp_column;
   logic        rsp_row_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = sedd_pkg::CSR_WIDTH;
   logic [10:0] csr_data = '0;

   serpentine_error_diffusion_dither DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model state
   logic [7:0] pal_colour [sedd_pkg::PAL_ENTRIES][3];
   int         err_acc [2][sedd_pkg::MAX_WIDTH][3];
   logic       row_odd;
   int         row_pos;
   int         cfg_width, cfg_level, cfg_trans;
   longint     colour_err [3];

   dither_word_type expected_words [$];
   int  fails = 0;
   int  hold_cycles = 0;
   bit  steady = 1'b0;
   int  items_sent = 0;

   function automatic int sat_acc(longint s);
      longint hi = (longint'(1) <<< (sedd_pkg::ERROR_BITS - 1)) - 1;
      if (s > hi) return int'(hi);
      if (s < -hi - 1) return int'(-hi - 1);
      return int'(s);
   endfunction

   function automatic void diffuse(int row, int col, int w, int share);
      longint p7, p5, p3, part;
      if (col < 0 || col >= w) return;
      for (int k = 0; k < 3; k++) begin
         p7 = (colour_err[k] * 7) / 16;
         p5 = (colour_err[k] * 5) / 16;
         p3 = (colour_err[k] * 3) / 16;
         case (share)
            7: part = p7;
            5: part = p5;
            3: part = p3;
            default: part = colour_err[k] - p7 - p5 - p3;
         endcase
         err_acc[row][col][k] = sat_acc(longint'(err_acc[row][col][k]) + part);
      end
   endfunction

   function automatic void clear_errors();
      for (int r = 0; r < 2; r++)
         for (int c = 0; c < sedd_pkg::MAX_WIDTH; c++)
            for (int k = 0; k < 3; k++) err_acc[r][c][k] = 0;
   endfunction

   function automatic dither_word_type dither_pixel(logic [7:0] r, logic [7:0] g,
                                                    logic [7:0] b, logic opq);
      dither_word_type res;
      int w, pos, col, dir, cur, nxt, lim, chosen;
      longint v [3];
      longint least, d, t;
      logic [7:0] px [3];
      bit last;
      px[0] = r; px[1] = g; px[2] = b;
      w = cfg_width;
      if (w < 1) w = 1;
      if (w > sedd_pkg::MAX_WIDTH) w = sedd_pkg::MAX_WIDTH;
      pos = (row_pos > w - 1) ? w - 1 : row_pos;
      col = row_odd ? (w - 1 - pos) : pos;
      dir = row_odd ? -1 : 1;
      cur = row_odd;
      nxt = cur ^ 1;
      last = (pos == w - 1);
      for (int k = 0; k < 3; k++)
         v[k] = longint'(px[k]) - (longint'(err_acc[cur][col][k]) * cfg_level) / 100;
      if (opq) begin
         lim = (cfg_trans > sedd_pkg::PAL_ENTRIES) ? sedd_pkg::PAL_ENTRIES : cfg_trans;
         least = longint'(sedd_pkg::SEARCH_LIMIT);
         chosen = 0;
         for (int i = 0; i < lim; i++) begin
            d = 0;
            for (int k = 0; k < 3; k++) begin
               t = v[k] - longint'(pal_colour[i][k]);
               d += t * t;
            end
            if (d < least) begin
               least = d;
               chosen = i;
            end
         end
      end else begin
         chosen = cfg_trans;
      end
      for (int k = 0; k < 3; k++)
         colour_err[k] = longint'(pal_colour[chosen][k]) - v[k];
      diffuse(cur, col + dir, w, 7);
      diffuse(nxt, col, w, 5);
      diffuse(nxt, col - dir, w, 3);
      diffuse(nxt, col + dir, w, 1);
      res.palette_index = chosen[7:0];
      res.column = col[9:0];
      res.row_last = last;
      if (last) begin
         for (int c = 0; c < sedd_pkg::MAX_WIDTH; c++)
            for (int k = 0; k < 3; k++) err_acc[cur][c][k] = 0;
         row_odd = ~row_odd;
         row_pos = 0;
      end else begin
         row_pos = pos + 1;
      end
      return res;
   endfunction

   function automatic void model_reset();
      clear_errors();
      row_odd = 1'b0;
      row_pos = 0;
      cfg_width = 1024;
      cfg_level = 100;
      cfg_trans = 255;
   endfunction

   function automatic int pick_gap();
      if (steady || $urandom_range(3) != 0) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(60, 10);
      return $urandom_range(3, 1);
   endfunction

   // called just after a falling edge; returns just after a falling edge
   task automatic send_word(logic [1:0] op, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                            logic [7:0] b, logic opq);
      int gap;
      req_opcode = op;
      req_entry_index = idx;
      req_red = r;
      req_green = g;
      req_blue = b;
      req_opaque = opq;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      case (op)
         sedd_pkg::OP_FRAME: begin
            clear_errors();
            row_odd = 1'b0;
            row_pos = 0;
         end
         sedd_pkg::OP_PALETTE: begin
            pal_colour[idx][0] = r;
            pal_colour[idx][1] = g;
            pal_colour[idx][2] = b;
         end
         sedd_pkg::OP_PIXEL: expected_words.push_back(dither_pixel(r, g, b, opq));
         default: ;
      endcase
      items_sent++;
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic opq);
      send_word(sedd_pkg::OP_PIXEL, 8'($urandom), r, g, b, opq);
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (IDLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [10:0] data);
      wait_idle();
      csr_index = idx;
      csr_data = data;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         sedd_pkg::CSR_WIDTH: cfg_width = data;
         sedd_pkg::CSR_LEVEL: cfg_level = data[6:0];
         sedd_pkg::CSR_TRANS: cfg_trans = data[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // receiver
   initial begin : rsp_driver
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready = 1'b0;
            hold_cycles--;
         end else if (stall > 0) begin
            rsp_ready = 1'b0;
            stall--;
         end else begin
            rsp_ready = 1'b1;
            if (!steady && $urandom_range(3) == 0)
               stall = ($urandom_range(15) == 0) ? $urandom_range(200, 20) : $urandom_range(3, 1);
         end
      end
   end

   always @(posedge clock) begin
      dither_word_type exp_w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected result word: index %0d column %0d",
                   rsp_palette_index, rsp_column);
            fails++;
         end else begin
            exp_w = expected_words.pop_front();
            if (rsp_palette_index !== exp_w.palette_index) begin
               $error("palette_index expected %0d actual %0d",
                      exp_w.palette_index, rsp_palette_index);
               fails++;
            end
            if (rsp_column !== exp_w.column) begin
               $error("column expected %0d actual %0d", exp_w.column, rsp_column);
               fails++;
            end
            if (rsp_row_last !== exp_w.row_last) begin
               $error("row_last expected %0d actual %0d", exp_w.row_last, rsp_row_last);
               fails++;
            end
         end
      end
   end

   task automatic test_load_palette();
      for (int i = 0; i < sedd_pkg::PAL_ENTRIES; i++)
         send_word(sedd_pkg::OP_PALETTE, i[7:0], 8'($urandom), 8'($urandom), 8'($urandom),
                   1'($urandom));
      send_word(sedd_pkg::OP_PALETTE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
      send_word(sedd_pkg::OP_PALETTE, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
   endtask

   task automatic test_full_width_and_shrink();
      write_csr(sedd_pkg::CSR_WIDTH, 11'd1024);
      send_word(sedd_pkg::OP_FRAME, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
      pixel(8'd0, 8'd0, 8'd0, 1'b1);
      pixel(8'd255, 8'd255, 8'd255, 1'b1);
      pixel(8'd128, 8'd7, 8'd200, 1'b1);
      write_csr(sedd_pkg::CSR_WIDTH, 11'd2);   // position now past the end: last column
      pixel(8'd10, 8'd20, 8'd30, 1'b1);
      pixel(8'd40, 8'd50, 8'd60, 1'b1);
      pixel(8'd70, 8'd80, 8'd90, 1'b1);
      write_csr(sedd_pkg::CSR_WIDTH, 11'd2047); // clamps to the maximum width
      send_word(sedd_pkg::OP_FRAME, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
      pixel(8'd1, 8'd2, 8'd3, 1'b1);
   endtask

   task automatic test_single_column();
      write_csr(sedd_pkg::CSR_WIDTH, 11'd0);
      send_word(sedd_pkg::OP_FRAME, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
      pixel(8'd255, 8'd0, 8'd255, 1'b1);
      pixel(8'd0, 8'd255, 8'd0, 1'b1);
      write_csr(sedd_pkg::CSR_WIDTH, 11'd1);
      pixel(8'd33, 8'd99, 8'd150, 1'b1);
   endtask

   task automatic test_levels_and_transparency();
      write_csr(sedd_pkg::CSR_WIDTH, 11'd3);
      write_csr(sedd_pkg::CSR_LEVEL, 11'd0);
      send_word(sedd_pkg::OP_FRAME, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
      repeat (3) pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
      write_csr(sedd_pkg::CSR_LEVEL, 11'd127);
      repeat (4) pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
      write_csr(sedd_pkg::CSR_TRANS, 11'd0);    // empty search, opaque maps to entry 0
      pixel(8'd200, 8'd100, 8'd50, 1'b1);
      pixel(8'd200, 8'd100, 8'd50, 1'b0);
      write_csr(sedd_pkg::CSR_TRANS, 11'd255);
      pixel(8'd9, 8'd9, 8'd9, 1'b0);
      send_word(OP_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
      pixel(8'd9, 8'd9, 8'd9, 1'b1);
      write_csr(sedd_pkg::CSR_LEVEL, 11'd100);
   endtask

   task automatic test_backpressure();
      write_csr(sedd_pkg::CSR_WIDTH, 11'd5);
      send_word(sedd_pkg::OP_FRAME, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
      @(negedge clock);
      hold_cycles = 4000;
      repeat (12) pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
   endtask

   task automatic test_random_frames();
      int w, lvl, tr, n, pick;
      while (items_sent < 1300) begin
         pick = $urandom_range(19);
         if (pick < 14) w = $urandom_range(12, 1);
         else if (pick < 16) w = $urandom_range(40, 13);
         else if (pick == 16) w = 0;
         else if (pick == 17) w = 1024;
         else w = $urandom_range(2047, 1025);
         pick = $urandom_range(9);
         lvl = (pick == 0) ? 0 : (pick == 1) ? 127 : (pick < 5) ? 100 : $urandom_range(127);
         pick = $urandom_range(9);
         tr = (pick == 0) ? 0 : (pick < 3) ? 255 : (pick < 6) ? $urandom_range(16) :
              $urandom_range(255);
         write_csr(sedd_pkg::CSR_WIDTH, w[10:0]);
         write_csr(sedd_pkg::CSR_LEVEL, lvl[10:0]);
         write_csr(sedd_pkg::CSR_TRANS, tr[10:0]);
         steady = ($urandom_range(4) == 0);
         send_word(sedd_pkg::OP_FRAME, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
         n = $urandom_range(120, 40);
         repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 88) pixel(8'($urandom), 8'($urandom), 8'($urandom),
                                 $urandom_range(7) != 0);
            else if (pick < 95) send_word(sedd_pkg::OP_PALETTE, 8'($urandom), 8'($urandom),
                                          8'($urandom), 8'($urandom), 1'($urandom));
            else if (pick < 98) send_word(sedd_pkg::OP_FRAME, 8'($urandom), 8'($urandom),
                                          8'($urandom), 8'($urandom), 1'($urandom));
            else send_word(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
                           8'($urandom), 1'($urandom));
         end
         steady = 1'b0;
      end
   endtask

   initial begin
      model_reset();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_load_palette();
      test_full_width_and_shrink();
      test_single_column();
      test_levels_and_transparency();
      test_backpressure();
      test_random_frames();
      wait_idle();
      if (fails == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/sedd_pkg.sv
rtl/sedd_ram.sv
rtl/serpentine_error_diffusion_dither.sv
bench/tb_top.sv
